// ----- src/lsg_pkg.sv -----
// Shared constants, types, gain tables and helpers for the lens shading gain block.
package lsg_pkg;

	localparam int GRID_COLS      = 8;
	localparam int GRID_ROWS      = 6;
	localparam int MAX_DIM        = 4096;
	localparam int GAIN_FRAC_BITS = 10;

	localparam int CFG_W    = 13;
	localparam int COORD_W  = 12;
	localparam int PIX_W    = 16;
	localparam int OUT_W    = 12;
	localparam int PIXEL_MAX = 4095;
	localparam int DIST_W   = 10;
	localparam int SUM_W    = DIST_W + 1;
	localparam int AREA_W   = 20;
	localparam int GAIN_W   = 11;
	localparam int NUM_W    = 31;
	localparam int XIDX_W   = 3;
	localparam int YIDX_W   = 3;
	localparam int GAIN_MAX = 1824;

	// Reciprocal multipliers for the knot positions (exact over the full span range)
	localparam int RECIP_SH = 20;
	localparam int KPROD_W  = 33;
	localparam int RECIP_X  = ((2 ** RECIP_SH) + GRID_COLS - 2) / (GRID_COLS - 1);
	localparam int RECIP_Y  = ((2 ** RECIP_SH) + GRID_ROWS - 2) / (GRID_ROWS - 1);

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PAR_EVEN  = 2'd0,
		PAR_MIXED = 2'd1,
		PAR_ODD   = 2'd2
	} par_t;

	// Payload that rides alongside the division pipeline
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             oof;
	} side_t;

	typedef logic [GAIN_W-1:0] gain_t;

	localparam gain_t TAB_EVEN [GRID_ROWS][GRID_COLS] = '{
		'{11'd1624, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1624, 11'd1824},
		'{11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1524, 11'd1724},
		'{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
		'{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
		'{11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1324, 11'd1624},
		'{11'd1824, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1524, 11'd1724}
	};

	localparam gain_t TAB_MIXED [GRID_ROWS][GRID_COLS] = '{
		'{11'd1624, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1624, 11'd1784},
		'{11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1584, 11'd1664},
		'{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
		'{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
		'{11'd1524, 11'd1324, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1424, 11'd1664},
		'{11'd1724, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1554, 11'd1784}
	};

	localparam gain_t TAB_ODD [GRID_ROWS][GRID_COLS] = '{
		'{11'd1224, 11'd1154, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1184, 11'd1324},
		'{11'd1164, 11'd1124, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1124, 11'd1164},
		'{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
		'{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
		'{11'd1324, 11'd1224, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1264, 11'd1324},
		'{11'd1424, 11'd1264, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1314, 11'd1484}
	};

	// Pick a corner gain from the table that matches the pixel parity
	function automatic gain_t gain_lookup(input par_t p, input logic [YIDX_W-1:0] r,
			input logic [XIDX_W-1:0] c);
		gain_t g;
		unique case (p)
			PAR_EVEN:  g = TAB_EVEN[r][c];
			PAR_MIXED: g = TAB_MIXED[r][c];
			PAR_ODD:   g = TAB_ODD[r][c];
			default:   g = TAB_MIXED[r][c];
		endcase
		return g;
	endfunction

endpackage

// ----- src/lens_shading_gain_interp.sv -----
// Lens shading gain: bilinear grid gain applied to a Bayer pixel stream.
// Transactions pass the numbered stages, the divider stages and the output register in order.
// Throughput: one transaction per cycle; a stall on the output freezes every stage.
// The 11-stage restoring divider (one gain bit per stage) sets the depth.
// Reset: arst_n clears valid bits and sets frame size to 1920 x 1080.
// Knot registers follow a configuration write after the frame size registers take it.
module lens_shading_gain_interp
	import lsg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [39:0]         s_tdata,   // pixel_in[15:0], col[27:16], row[39:28]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // pixel_out[11:0], zero fill[15:12]
	output logic [0:0]          m_tuser,   // out_of_frame[0]
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata
);

	logic [CFG_W-1:0]   frame_width_q;
	logic [CFG_W-1:0]   frame_height_q;
	logic [CFG_W-1:0]   w_use;
	logic [CFG_W-1:0]   h_use;
	logic [COORD_W-1:0] xknot [GRID_COLS];
	logic [COORD_W-1:0] yknot [GRID_ROWS];
	logic               en;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_W'(1920);
			frame_height_q <= CFG_W'(1080);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	// Clamp oversized frames
	assign w_use = (frame_width_q > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : frame_width_q;
	assign h_use = (frame_height_q > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : frame_height_q;

	lsg_grid u_grid (
		.clk    (clk),
		.width  (w_use),
		.height (h_use),
		.xknot  (xknot),
		.yknot  (yknot)
	);

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: capture the transaction, frame check and parity
	logic               s1_vld;
	logic [PIX_W-1:0]   s1_pix;
	logic [COORD_W-1:0] s1_col, s1_row;
	logic               s1_oof;
	par_t               s1_par;
	logic [COORD_W-1:0] in_col, in_row;
	par_t               in_par;

	assign in_col = s_tdata[27:16];
	assign in_row = s_tdata[39:28];

	always_comb begin
		if (!in_col[0] && !in_row[0]) in_par = PAR_EVEN;
		else if (in_col[0] && in_row[0]) in_par = PAR_ODD;
		else in_par = PAR_MIXED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_vld <= 1'b0;
		else if (en) s1_vld <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_pix <= s_tdata[15:0];
			s1_col <= in_col;
			s1_row <= in_row;
			s1_oof <= (CFG_W'(in_col) >= w_use) || (CFG_W'(in_row) >= h_use);
			s1_par <= in_par;
		end
	end

	// Stage 2: locate the grid cell and distances to its knots
	logic [XIDX_W-1:0] xi_d;
	logic [YIDX_W-1:0] yi_d;
	logic [DIST_W-1:0] x1_d, x2_d, y1_d, y2_d;

	always_comb begin
		xi_d = '0;
		for (int i = GRID_COLS - 1; i >= 1; i--) begin
			if (s1_col <= xknot[i]) xi_d = XIDX_W'(i - 1);
		end
		yi_d = '0;
		for (int j = GRID_ROWS - 1; j >= 1; j--) begin
			if (s1_row <= yknot[j]) yi_d = YIDX_W'(j - 1);
		end
		x1_d = DIST_W'(s1_col - xknot[xi_d]);
		x2_d = DIST_W'(xknot[xi_d + XIDX_W'(1)] - s1_col);
		if (x1_d == '0 && x2_d == '0) x2_d = DIST_W'(1);
		y1_d = DIST_W'(s1_row - yknot[yi_d]);
		y2_d = DIST_W'(yknot[yi_d + YIDX_W'(1)] - s1_row);
		if (y1_d == '0 && y2_d == '0) y2_d = DIST_W'(1);
	end

	logic              s2_vld;
	logic [PIX_W-1:0]  s2_pix;
	logic              s2_oof;
	par_t              s2_par;
	logic [XIDX_W-1:0] s2_xi;
	logic [YIDX_W-1:0] s2_yi;
	logic [DIST_W-1:0] s2_x1, s2_x2, s2_y1, s2_y2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s2_vld <= 1'b0;
		else if (en) s2_vld <= s1_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2_pix <= s1_pix;
			s2_oof <= s1_oof;
			s2_par <= s1_par;
			s2_xi  <= xi_d;
			s2_yi  <= yi_d;
			s2_x1  <= x1_d;
			s2_x2  <= x2_d;
			s2_y1  <= y1_d;
			s2_y2  <= y2_d;
		end
	end

	// Stage 3: corner gains, bilinear weights and cell area
	logic              s3_vld;
	logic [PIX_W-1:0]  s3_pix;
	logic              s3_oof;
	gain_t             s3_g0, s3_g1, s3_g2, s3_g3;
	logic [AREA_W-1:0] s3_w0, s3_w1, s3_w2, s3_w3, s3_area;
	logic [SUM_W-1:0]  xsum, ysum;

	assign xsum = SUM_W'(s2_x1) + SUM_W'(s2_x2);
	assign ysum = SUM_W'(s2_y1) + SUM_W'(s2_y2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s3_vld <= 1'b0;
		else if (en) s3_vld <= s2_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s3_pix  <= s2_pix;
			s3_oof  <= s2_oof;
			s3_g0   <= gain_lookup(s2_par, s2_yi, s2_xi);
			s3_g1   <= gain_lookup(s2_par, s2_yi, s2_xi + XIDX_W'(1));
			s3_g2   <= gain_lookup(s2_par, s2_yi + YIDX_W'(1), s2_xi);
			s3_g3   <= gain_lookup(s2_par, s2_yi + YIDX_W'(1), s2_xi + XIDX_W'(1));
			s3_w0   <= AREA_W'(s2_x2) * AREA_W'(s2_y2);
			s3_w1   <= AREA_W'(s2_x1) * AREA_W'(s2_y2);
			s3_w2   <= AREA_W'(s2_x2) * AREA_W'(s2_y1);
			s3_w3   <= AREA_W'(s2_x1) * AREA_W'(s2_y1);
			s3_area <= AREA_W'(AREA_W'(xsum) * AREA_W'(ysum));
		end
	end

	// Stage 4: weight each corner gain
	logic              s4_vld;
	logic [PIX_W-1:0]  s4_pix;
	logic              s4_oof;
	logic [AREA_W-1:0] s4_area;
	logic [NUM_W-1:0]  s4_p0, s4_p1, s4_p2, s4_p3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s4_vld <= 1'b0;
		else if (en) s4_vld <= s3_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s4_pix  <= s3_pix;
			s4_oof  <= s3_oof;
			s4_area <= s3_area;
			s4_p0   <= NUM_W'(s3_w0) * NUM_W'(s3_g0);
			s4_p1   <= NUM_W'(s3_w1) * NUM_W'(s3_g1);
			s4_p2   <= NUM_W'(s3_w2) * NUM_W'(s3_g2);
			s4_p3   <= NUM_W'(s3_w3) * NUM_W'(s3_g3);
		end
	end

	// Stage 5: sum the weighted gains
	logic              s5_vld;
	side_t             s5_side;
	logic [AREA_W-1:0] s5_area;
	logic [NUM_W-1:0]  s5_num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s5_vld <= 1'b0;
		else if (en) s5_vld <= s4_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s5_side.pix <= s4_pix;
			s5_side.oof <= s4_oof;
			s5_area     <= s4_area;
			s5_num      <= s4_p0 + s4_p1 + s4_p2 + s4_p3;
		end
	end

	// Divide by the cell area
	logic  dv_vld;
	gain_t dv_gain;
	side_t dv_side;

	lsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s5_vld),
		.in_num   (s5_num),
		.in_area  (s5_area),
		.in_side  (s5_side),
		.out_vld  (dv_vld),
		.out_quo  (dv_gain),
		.out_side (dv_side)
	);

	// Output stage: apply gain, drop fraction bits, clip; out-of-frame results carry a zero pixel
	localparam int PROD_W = PIX_W + GAIN_W;
	logic [PROD_W-1:0]                val_d;
	logic [PROD_W-GAIN_FRAC_BITS-1:0] shf_d;
	logic [OUT_W-1:0]                 pix_d;
	logic [OUT_W-1:0]                 pixel_out_q;
	logic                             oof_q;
	logic                             out_vld_q;

	always_comb begin
		val_d = PROD_W'(dv_side.pix) * PROD_W'(dv_gain);
		shf_d = val_d[PROD_W-1:GAIN_FRAC_BITS];
		if (dv_side.oof) pix_d = '0;
		else if (shf_d > (PROD_W - GAIN_FRAC_BITS)'(PIXEL_MAX)) pix_d = OUT_W'(PIXEL_MAX);
		else pix_d = OUT_W'(shf_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_out_q <= pix_d;
			oof_q       <= dv_side.oof;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0, pixel_out_q};
	assign m_tuser  = oof_q;

	// Out-of-frame results carry a zero pixel
	a_oof_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[OUT_W-1:0] == '0)
		else $error("out-of-frame result with nonzero pixel");

	// In-frame cells never have a zero extent
	a_cell_ext: assert property (@(posedge clk) disable iff (!arst_n)
		s2_vld && !s2_oof |-> xsum != '0 && ysum != '0)
		else $error("zero cell extent");

	// Area is nonzero for in-frame items
	a_area: assert property (@(posedge clk) disable iff (!arst_n)
		s3_vld && !s3_oof |-> s3_area != '0)
		else $error("zero cell area");

	// Interpolated gain stays within the table range
	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld && !dv_side.oof |-> dv_gain <= GAIN_W'(GAIN_MAX))
		else $error("interpolated gain above table maximum");

endmodule

// ----- src/lsg_grid.sv -----
// Grid knot positions derived from the configured frame size, registered.
module lsg_grid
	import lsg_pkg::*;
(
	input  logic               clk,
	input  logic [CFG_W-1:0]   width,
	input  logic [CFG_W-1:0]   height,
	output logic [COORD_W-1:0] xknot [GRID_COLS],
	output logic [COORD_W-1:0] yknot [GRID_ROWS]
);

	logic [COORD_W-1:0] xspan;
	logic [COORD_W-1:0] yspan;
	logic [COORD_W-1:0] xknot_d [GRID_COLS];
	logic [COORD_W-1:0] yknot_d [GRID_ROWS];

	assign xspan = COORD_W'(width - CFG_W'(1));
	assign yspan = COORD_W'(height - CFG_W'(1));

	// Scale each knot index by the span and divide by the interval count
	always_comb begin
		for (int i = 0; i < GRID_COLS; i++) begin
			xknot_d[i] = COORD_W'((KPROD_W'(KPROD_W'(i) * KPROD_W'(xspan))
				* KPROD_W'(RECIP_X)) >> RECIP_SH);
		end
		for (int j = 0; j < GRID_ROWS; j++) begin
			yknot_d[j] = COORD_W'((KPROD_W'(KPROD_W'(j) * KPROD_W'(yspan))
				* KPROD_W'(RECIP_Y)) >> RECIP_SH);
		end
	end

	// Hold knots in registers
	always_ff @(posedge clk) begin
		xknot <= xknot_d;
		yknot <= yknot_d;
	end

endmodule

// ----- src/lsg_div.sv -----
// Pipelined restoring divider: one quotient bit per stage.
module lsg_div
	import lsg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [AREA_W-1:0] in_area,
	input  side_t             in_side,
	output logic              out_vld,
	output gain_t             out_quo,
	output side_t             out_side
);

	logic              vld_q  [GAIN_W];
	logic [NUM_W-1:0]  rem_q  [GAIN_W];
	logic [AREA_W-1:0] area_q [GAIN_W];
	gain_t             quo_q  [GAIN_W];
	side_t             side_q [GAIN_W];

	logic [NUM_W-1:0]  rem_in  [GAIN_W];
	logic [AREA_W-1:0] area_in [GAIN_W];
	gain_t             quo_in  [GAIN_W];
	logic [NUM_W-1:0]  rem_d   [GAIN_W];
	gain_t             quo_d   [GAIN_W];
	logic [NUM_W-1:0]  dvs     [GAIN_W];

	// Compare and subtract the shifted divisor, most significant bit first
	always_comb begin
		for (int k = 0; k < GAIN_W; k++) begin
			if (k == 0) begin
				rem_in[k]  = in_num;
				area_in[k] = in_area;
				quo_in[k]  = '0;
			end else begin
				rem_in[k]  = rem_q[k-1];
				area_in[k] = area_q[k-1];
				quo_in[k]  = quo_q[k-1];
			end
			dvs[k]   = NUM_W'(area_in[k]) << (GAIN_W - 1 - k);
			rem_d[k] = rem_in[k];
			quo_d[k] = quo_in[k];
			if (rem_in[k] >= dvs[k]) begin
				rem_d[k] = rem_in[k] - dvs[k];
				quo_d[k][GAIN_W-1-k] = 1'b1;
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < GAIN_W; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_vld;
			for (int k = 1; k < GAIN_W; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= in_side;
			for (int k = 0; k < GAIN_W; k++) begin
				rem_q[k]  <= rem_d[k];
				area_q[k] <= area_in[k];
				quo_q[k]  <= quo_d[k];
				if (k > 0) side_q[k] <= side_q[k-1];
			end
		end
	end

	assign out_vld  = vld_q[GAIN_W-1];
	assign out_quo  = quo_q[GAIN_W-1];
	assign out_side = side_q[GAIN_W-1];

endmodule

// ----- tb/sv/lens_shading_gain_interp_tb.sv -----
// Testbench for the lens shading gain block: predicts gained pixels and checks the output stream.
module lens_shading_gain_interp_tb;
	import lsg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [OUT_W-1:0] pix;
		logic             oof;
	} shade_res_t;

	// Holds the frame size and the queue of predicted shaded pixels
	class shade_board;
		int unsigned width_cfg;
		int unsigned height_cfg;
		shade_res_t  pending[$];
		int          errors;

		function new();
			width_cfg = 1920;
			height_cfg = 1080;
			errors = 0;
		endfunction

		// Find the knot interval, the lower distance and the upper distance
		function automatic void find_cell(input int unsigned c, input int unsigned span,
				input int unsigned n, output int unsigned idx, output longint unsigned dlo,
				output longint unsigned dhi);
			longint unsigned lo, hi;
			idx = 0;
			dlo = 0;
			dhi = 1;
			for (int unsigned i = 1; i < n; i++) begin
				lo = (longint'(i - 1) * span) / (n - 1);
				hi = (longint'(i) * span) / (n - 1);
				if (i == n - 1)
					hi = span;
				if (c <= hi) begin
					idx = i - 1;
					dlo = c - lo;
					dhi = hi - c;
					if (dlo + dhi == 0)
						dhi = 1;
					return;
				end
			end
		endfunction

		function automatic int unsigned corner(input par_t p, input int unsigned r,
				input int unsigned c);
			case (p)
				PAR_EVEN:  return TAB_EVEN[r][c];
				PAR_ODD:   return TAB_ODD[r][c];
				default:   return TAB_MIXED[r][c];
			endcase
		endfunction

		function void note_pixel(input logic [15:0] pix, input logic [11:0] col,
				input logic [11:0] row);
			shade_res_t r;
			int unsigned w, h, xi, yi;
			longint unsigned x1, x2, y1, y2, num, gain, val;
			par_t p;
			w = (width_cfg > MAX_DIM) ? MAX_DIM : width_cfg;
			h = (height_cfg > MAX_DIM) ? MAX_DIM : height_cfg;
			if (col >= w || row >= h) begin
				r.pix = '0;
				r.oof = 1'b1;
			end else begin
				find_cell(col, w - 1, GRID_COLS, xi, x1, x2);
				find_cell(row, h - 1, GRID_ROWS, yi, y1, y2);
				if (!col[0] && !row[0])
					p = PAR_EVEN;
				else if (col[0] && row[0])
					p = PAR_ODD;
				else
					p = PAR_MIXED;
				num = x2 * y2 * corner(p, yi, xi) + x1 * y2 * corner(p, yi, xi + 1)
					+ x2 * y1 * corner(p, yi + 1, xi) + x1 * y1 * corner(p, yi + 1, xi + 1);
				gain = num / ((x1 + x2) * (y1 + y2));
				val = (longint'(pix) * gain) >> GAIN_FRAC_BITS;
				if (val > PIXEL_MAX)
					val = PIXEL_MAX;
				r.pix = val[OUT_W-1:0];
				r.oof = 1'b0;
			end
			pending.push_back(r);
		endfunction

		function void check_pixel(input logic [15:0] tdata, input logic tuser);
			shade_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected transaction pixel_out=%0d out_of_frame=%0b",
					$time, tdata[11:0], tuser);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (tdata[11:0] !== e.pix) begin
				$display("%0t: pixel_out expected %0d actual %0d", $time, e.pix, tdata[11:0]);
				errors++;
			end
			if (tdata[15:12] !== 4'd0) begin
				$display("%0t: zero fill expected 0 actual %0h", $time, tdata[15:12]);
				errors++;
			end
			if (tuser !== e.oof) begin
				$display("%0t: out_of_frame expected %0b actual %0b", $time, e.oof, tuser);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [39:0]       s_tdata;   // pixel_in[15:0], col[27:16], row[39:28]
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;   // pixel_out[11:0], zero fill[15:12]
	logic [0:0]        m_tuser;   // out_of_frame[0]
	logic              cfg_we;
	logic [0:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	shade_board board;
	bit         stall_on;

	lens_shading_gain_interp u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Note inputs and check outputs on each accepted transaction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.note_pixel(s_tdata[15:0], s_tdata[27:16], s_tdata[39:28]);
		if (arst_n && m_tvalid && m_tready)
			board.check_pixel(m_tdata, m_tuser[0]);
	end

	// Stall the output on random cycles while stalls are on, with calm phases otherwise
	always @(posedge clk) begin
		if (!stall_on)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			board.width_cfg = 32'(val[CFG_W-1:0]);
		else
			board.height_cfg = 32'(val[CFG_W-1:0]);
		@(posedge clk);
	endtask

	// Drive one transaction and hold it until accepted
	task automatic send_pixel(input logic [15:0] pix, input logic [11:0] col,
			input logic [11:0] row);
		s_tvalid <= 1'b1;
		s_tdata <= {row, col, pix};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic idle_gap(input int unsigned n);
		if (n == 0)
			return;
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait until every prediction has been matched, then let the pipe drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned count, input int unsigned w,
			input int unsigned h);
		int unsigned sent, burst;
		logic [11:0] c, r;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int unsigned k = 0; k < burst && sent < count; k++) begin
				// Mostly in-frame coordinates, some fully random ones
				if ($urandom_range(0, 9) == 0) begin
					c = 12'($urandom);
					r = 12'($urandom);
				end else begin
					c = 12'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
					r = 12'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
				end
				send_pixel(16'($urandom), c, r);
				sent++;
			end
			idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
		end
		drain();
	endtask

	initial begin
		int unsigned widths[6];
		int unsigned heights[6];
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_wdata = '0;
		stall_on = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset frame size, field extremes, parities, edges, outside frame
		send_pixel(16'h0000, 12'd0, 12'd0);
		send_pixel(16'hFFFF, 12'd0, 12'd0);
		send_pixel(16'hFFFF, 12'd1919, 12'd1079);
		send_pixel(16'd3000, 12'd1, 12'd0);
		send_pixel(16'd3000, 12'd1, 12'd1);
		send_pixel(16'd3000, 12'd0, 12'd1);
		send_pixel(16'd2500, 12'd274, 12'd215);
		send_pixel(16'd1234, 12'd1920, 12'd5);
		send_pixel(16'd1234, 12'd5, 12'd1080);
		send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
		send_pixel(16'h5555, 12'hAAA, 12'h555);
		drain();

		// Oversized and small frames, degenerate cells
		write_reg(REG_FRAME_WIDTH, 13'h1FFF);
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
		send_pixel(16'hAAAA, 12'h555, 12'hAAA);
		send_pixel(16'd4000, 12'd2048, 12'd3000);
		drain();
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 2);
		send_pixel(16'd4096, 12'd0, 12'd0);
		send_pixel(16'd4096, 12'd1, 12'd0);
		send_pixel(16'd4096, 12'd1, 12'd1);
		send_pixel(16'd4096, 12'd2, 12'd1);
		drain();
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 4096);
		send_pixel(16'd100, 12'd0, 12'd0);
		drain();

		// Random phases over several frame sizes
		widths = '{1920, 2, 4096, 9, 640, 8191};
		heights = '{1080, 3, 4096, 7, 480, 4100};
		foreach (widths[i]) begin
			write_reg(REG_FRAME_WIDTH, widths[i]);
			write_reg(REG_FRAME_HEIGHT, heights[i]);
			stall_on = (i % 3 != 2);
			random_phase(170, widths[i], heights[i]);
		end

		if (board.errors == 0)
			$display("lens_shading_gain_interp_tb: PASS");
		else
			$display("lens_shading_gain_interp_tb: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("lens_shading_gain_interp_tb: FAIL");
		$finish;
	end
endmodule
